@@ rtl/core/rtlp_pkg.sv @@
// ---------------------------------------------------------------------------
// Route table package
// Shared constants and types for the longest-prefix route table.
// ---------------------------------------------------------------------------
package rtlp_pkg;

    localparam int ROUTE_ENTRIES_DEF = 16;

    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_ADD     = 2'd1,
        OP_REM_IDX = 2'd2,
        OP_REM_HOP = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_ADD,
        FSM_REMIDX,
        FSM_HOPSCAN,
        FSM_COMPACT,
        FSM_REPORT,
        FSM_DONE
    } t_fsm;

endpackage

@@ rtl/core/route_table_longest_prefix.sv @@
// ---------------------------------------------------------------------------
// Route table with longest-prefix match
// IPv6 route table: lookup, add or update, remove by slot, remove by hop.
// ---------------------------------------------------------------------------
// Lookup scans the list; add scans it and then writes or updates; remove by index
// clears a valid slot and compacts the list; remove by next hop checks every slot and
// compacts after each match. One request is in flight at a time, one list position
// or slot per cycle through a single prefix comparator and a single list compaction
// step. A new request is taken the cycle after the result is taken.
// Reset (synchronous, active low) empties the list and clears all valid bits.
module route_table_longest_prefix #(
    parameter int ROUTE_ENTRIES = rtlp_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_opcode,
    input  logic [63:0]   i_addr_high,
    input  logic [63:0]   i_addr_low,
    input  logic [7:0]    i_prefix_len,
    input  logic [63:0]   i_hop_high,
    input  logic [63:0]   i_hop_low,
    input  logic [7:0]    i_route_metric,
    input  logic [3:0]    i_slot_index,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_status,
    output logic [3:0]    o_result_slot,
    output logic [63:0]   o_found_hop_high,
    output logic [63:0]   o_found_hop_low,
    output logic [7:0]    o_found_len,
    output logic [7:0]    o_found_metric,
    output logic [4:0]    o_route_count,
    output logic [4:0]    o_removed_count
);

    localparam int SW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW = $clog2(ROUTE_ENTRIES + 1);

    // Table storage
    logic [127:0] r_prefix [ROUTE_ENTRIES];
    logic [7:0]   r_len    [ROUTE_ENTRIES];
    logic [127:0] r_hop    [ROUTE_ENTRIES];
    logic [7:0]   r_metric [ROUTE_ENTRIES];
    logic [SW-1:0] r_order [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] r_slot_valid;
    logic [CW-1:0] r_list_len;

    // Request registers
    logic [1:0]   r_op;
    logic [127:0] r_addr, r_hopin;
    logic [7:0]   r_plen, r_pmetric;
    logic [3:0]   r_idx;

    // Sequencer state
    rtlp_pkg::t_fsm r_state, n_state;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_wpos;
    logic [SW-1:0] r_target;
    logic [SW-1:0] r_best;
    logic          r_found;
    logic [7:0]    r_longest;
    logic [CW-1:0] r_slot;
    logic [4:0]    r_removed;
    logic          r_out_valid;

    // Output registers
    logic [1:0]   r_status;
    logic [3:0]   r_rslot;
    logic [127:0] r_fhop;
    logic [7:0]   r_flen, r_fmet;
    logic [4:0]   r_rcount;

    logic accept_in;
    logic pos_end;
    logic [SW-1:0] cur_slot;
    logic [127:0] cur_mask;
    logic cur_match;
    logic [SW-1:0] free_slot;
    logic free_any;
    logic [SW-1:0] idx_sw;
    logic idx_ok;

    assign accept_in = i_valid && !o_stall;
    assign pos_end   = (r_pos >= r_list_len);
    assign cur_slot  = r_order[r_pos[SW-1:0]];

    // Shared prefix comparator on the entry at the current list position
    always_comb begin
        for (int b = 0; b < 128; b++) begin
            cur_mask[127-b] = (8'(b) < r_len[cur_slot]);
        end
        cur_match = (((r_addr ^ r_prefix[cur_slot]) & cur_mask) == 128'd0);
    end

    // Lowest free slot
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int k = ROUTE_ENTRIES - 1; k >= 0; k--) begin
            if (!r_slot_valid[k]) begin
                free_slot = SW'(k);
                free_any  = 1'b1;
            end
        end
    end

    assign idx_sw = SW'(r_idx);
    assign idx_ok = ({28'd0, r_idx} < ROUTE_ENTRIES) && r_slot_valid[idx_sw];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rtlp_pkg::FSM_IDLE: begin
                if (accept_in) begin
                    case (rtlp_pkg::t_opcode'(i_opcode))
                        rtlp_pkg::OP_LOOKUP, rtlp_pkg::OP_ADD: n_state = rtlp_pkg::FSM_SCAN;
                        rtlp_pkg::OP_REM_IDX: n_state = rtlp_pkg::FSM_REMIDX;
                        default: n_state = rtlp_pkg::FSM_HOPSCAN;
                    endcase
                end
            end
            rtlp_pkg::FSM_SCAN: begin
                if (pos_end) begin
                    n_state = (r_op == rtlp_pkg::OP_ADD) ? rtlp_pkg::FSM_ADD
                                                         : rtlp_pkg::FSM_REPORT;
                end
            end
            rtlp_pkg::FSM_ADD:    n_state = rtlp_pkg::FSM_REPORT;
            rtlp_pkg::FSM_REMIDX: n_state = idx_ok ? rtlp_pkg::FSM_COMPACT
                                                   : rtlp_pkg::FSM_REPORT;
            rtlp_pkg::FSM_HOPSCAN: begin
                if (r_slot >= CW'(ROUTE_ENTRIES)) begin
                    n_state = rtlp_pkg::FSM_REPORT;
                end else if (r_slot_valid[r_slot[SW-1:0]]
                             && r_hop[r_slot[SW-1:0]] == r_hopin) begin
                    n_state = rtlp_pkg::FSM_COMPACT;
                end
            end
            rtlp_pkg::FSM_COMPACT: begin
                if (pos_end) begin
                    n_state = (r_op == rtlp_pkg::OP_REM_HOP) ? rtlp_pkg::FSM_HOPSCAN
                                                             : rtlp_pkg::FSM_REPORT;
                end
            end
            rtlp_pkg::FSM_REPORT: n_state = rtlp_pkg::FSM_DONE;
            rtlp_pkg::FSM_DONE: begin
                if (!r_out_valid || !i_stall) n_state = rtlp_pkg::FSM_IDLE;
            end
            default: n_state = rtlp_pkg::FSM_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_stall = (r_state != rtlp_pkg::FSM_IDLE) || (r_out_valid && i_stall);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rtlp_pkg::FSM_IDLE;
            r_slot_valid <= '0;
            r_list_len   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            case (r_state)
                rtlp_pkg::FSM_ADD: begin
                    if (!r_found && free_any && r_list_len < CW'(ROUTE_ENTRIES)) begin
                        r_slot_valid[free_slot] <= 1'b1;
                        r_list_len <= r_list_len + 1'b1;
                    end
                end
                rtlp_pkg::FSM_REMIDX: begin
                    if (idx_ok) r_slot_valid[idx_sw] <= 1'b0;
                end
                rtlp_pkg::FSM_HOPSCAN: begin
                    if (r_slot < CW'(ROUTE_ENTRIES) && r_slot_valid[r_slot[SW-1:0]]
                        && r_hop[r_slot[SW-1:0]] == r_hopin) begin
                        r_slot_valid[r_slot[SW-1:0]] <= 1'b0;
                    end
                end
                rtlp_pkg::FSM_COMPACT: begin
                    if (pos_end) r_list_len <= r_wpos;
                end
                rtlp_pkg::FSM_REPORT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers and table writes
    always_ff @(posedge i_clk) begin
        case (r_state)
            rtlp_pkg::FSM_IDLE: begin
                if (accept_in) begin
                    r_op      <= i_opcode;
                    r_addr    <= {i_addr_high, i_addr_low};
                    r_hopin   <= {i_hop_high, i_hop_low};
                    r_plen    <= (i_prefix_len > 8'd128) ? 8'd128 : i_prefix_len;
                    r_pmetric <= i_route_metric;
                    r_idx     <= i_slot_index;
                    r_pos     <= '0;
                    r_wpos    <= '0;
                    r_slot    <= '0;
                    r_found   <= 1'b0;
                    r_longest <= '0;
                    r_best    <= '0;
                    r_removed <= '0;
                end
            end
            rtlp_pkg::FSM_SCAN: begin
                if (!pos_end) begin
                    if (r_slot_valid[cur_slot] && r_len[cur_slot] >= r_longest
                        && cur_match) begin
                        r_longest <= r_len[cur_slot];
                        r_best    <= cur_slot;
                        r_found   <= 1'b1;
                    end
                    r_pos <= r_pos + 1'b1;
                end
            end
            rtlp_pkg::FSM_ADD: begin
                if (!r_found && free_any && r_list_len < CW'(ROUTE_ENTRIES)) begin
                    r_order[r_list_len[SW-1:0]] <= free_slot;
                    r_best  <= free_slot;
                    r_found <= 1'b1;
                    r_prefix[free_slot] <= r_addr;
                    r_len[free_slot]    <= r_plen;
                    r_hop[free_slot]    <= r_hopin;
                    r_metric[free_slot] <= r_pmetric;
                end else if (r_found) begin
                    r_prefix[r_best] <= r_addr;
                    r_len[r_best]    <= r_plen;
                    r_hop[r_best]    <= r_hopin;
                    r_metric[r_best] <= r_pmetric;
                end
            end
            rtlp_pkg::FSM_REMIDX: begin
                r_target <= idx_sw;
                r_pos    <= '0;
                r_wpos   <= '0;
                if (idx_ok) r_removed <= 5'd1;
            end
            rtlp_pkg::FSM_HOPSCAN: begin
                r_pos  <= '0;
                r_wpos <= '0;
                if (r_slot < CW'(ROUTE_ENTRIES)) begin
                    r_target <= r_slot[SW-1:0];
                    r_slot   <= r_slot + 1'b1;
                    if (r_slot_valid[r_slot[SW-1:0]] && r_hop[r_slot[SW-1:0]] == r_hopin) begin
                        r_removed <= r_removed + 1'b1;
                    end
                end
            end
            rtlp_pkg::FSM_COMPACT: begin
                // One list position per cycle, dropping the target slot
                if (!pos_end) begin
                    if (cur_slot != r_target) begin
                        r_order[r_wpos[SW-1:0]] <= cur_slot;
                        r_wpos <= r_wpos + 1'b1;
                    end
                    r_pos <= r_pos + 1'b1;
                end
            end
            rtlp_pkg::FSM_REPORT: begin
                r_rcount <= 5'(r_list_len);
                r_fhop   <= '0;
                r_flen   <= '0;
                r_fmet   <= '0;
                r_rslot  <= '0;
                case (rtlp_pkg::t_opcode'(r_op))
                    rtlp_pkg::OP_LOOKUP, rtlp_pkg::OP_ADD: begin
                        if (r_found) begin
                            r_status <= rtlp_pkg::ST_OK;
                            r_rslot  <= 4'(r_best);
                            r_fhop   <= r_hop[r_best];
                            r_flen   <= r_len[r_best];
                            r_fmet   <= r_metric[r_best];
                        end else begin
                            r_status <= (r_op == rtlp_pkg::OP_ADD) ? rtlp_pkg::ST_FULL
                                                                   : rtlp_pkg::ST_NOTFOUND;
                        end
                    end
                    rtlp_pkg::OP_REM_IDX: begin
                        r_rslot  <= r_idx;
                        r_status <= (r_removed != 5'd0) ? rtlp_pkg::ST_OK
                                                        : rtlp_pkg::ST_NOTFOUND;
                    end
                    default: begin
                        r_status <= (r_removed != 5'd0) ? rtlp_pkg::ST_OK
                                                        : rtlp_pkg::ST_NOTFOUND;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_result_slot    = r_rslot;
    assign o_found_hop_high = r_fhop[127:64];
    assign o_found_hop_low  = r_fhop[63:0];
    assign o_found_len      = r_flen;
    assign o_found_metric   = r_fmet;
    assign o_route_count    = r_rcount;
    assign o_removed_count  = r_removed;

endmodule
